@@ sv/nll_pkg.sv @@
package nll_pkg;

  // Defaults for the top-level parameters.
  localparam int FRAC_DEF = 14;
  localparam int ITER_DEF = 20;

  // Input component width, fixed by the word format.
  localparam int COMP_W = 16;

  // Rotator datapath width. It covers the widest square root, the prescale and the gain.
  localparam int CW = 60;
  // Angle accumulator width, in 2^-32 turn units, with sign and headroom.
  localparam int AW = 36;
  // Vectors are scaled up by 2^24 before rotation.
  localparam int PRESCALE_SH = 24;

  localparam logic signed [AW-1:0] HALF_TURN = 36'sh0_8000_0000;
  localparam logic signed [AW-1:0] FULL_TURN = 36'sh1_0000_0000;

  // Control that travels with each word.
  typedef struct packed {
    logic valid;
    logic pole;
    logic zpos;
  } ctl_t;

  // State of one rotator lane. When fixed is set, acc already holds the final angle.
  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [AW-1:0] acc;
    logic          fixed;
  } cord_t;

  // Arctangent of 2^-i in 2^-32 turn units.
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

@@ sv/nll_in_if.sv @@
interface nll_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;

  modport source(output valid, output normal_x, output normal_y, output normal_z,
                 input ready);
  modport sink(input valid, input normal_x, input normal_y, input normal_z,
               output ready);
endinterface

@@ sv/nll_out_if.sv @@
interface nll_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] longitude_code;
  logic [7:0] latitude_code;

  modport source(output valid, output longitude_code, output latitude_code, input ready);
  modport sink(input valid, input longitude_code, input latitude_code, output ready);
endinterface

@@ sv/normal_to_latlong_bytes.sv @@
// Encodes a unit normal (signed components, 2^COMPONENT_FRACTION_BITS means one) as two angle
// bytes: longitude_code is the polar angle from +z and latitude_code the azimuth atan2(y, x),
// both in units of 360/255 degrees. A new word is taken every cycle while the output is not
// stalled, and results come out in order. The path runs through the square-root pipeline, one
// stage per result bit, followed by the two arctangent rotators, one stage per iteration. A stall
// on the output holds the whole pipeline.
module normal_to_latlong_bytes
  import nll_pkg::*;
#(
  parameter int COMPONENT_FRACTION_BITS = FRAC_DEF,
  parameter int ANGLE_ITERATIONS        = ITER_DEF
) (
  input logic     clk,
  input logic     rst_n,
  nll_in_if.sink  in_ch,
  nll_out_if.source out_ch
);

  localparam int FRAC = COMPONENT_FRACTION_BITS;
  localparam int ITER = ANGLE_ITERATIONS;
  localparam int ZW   = (FRAC+2 > COMP_W+1) ? FRAC+2 : COMP_W+1;
  localparam int NW   = 2*FRAC+2;
  localparam int NS   = FRAC+1;

  logic en;

  ctl_t                     ctl_s [0:NS];
  logic signed [COMP_W-1:0] x_s   [0:NS];
  logic signed [COMP_W-1:0] y_s   [0:NS];
  logic [ZW-1:0]            z_s   [0:NS];
  logic [NW-1:0]            n_s   [0:NS];
  logic [NW-1:0]            res_s [0:NS];

  ctl_t  ctl_c [0:ITER];
  cord_t lat_c [0:ITER];
  cord_t lon_c [0:ITER];

  // The pipeline moves whenever the output register is free or being drained.
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  nll_front #(.FRAC(FRAC)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_valid(in_ch.valid),
    .in_x    (in_ch.normal_x),
    .in_y    (in_ch.normal_y),
    .in_z    (in_ch.normal_z),
    .ctl_r   (ctl_s[0]),
    .x_r     (x_s[0]),
    .y_r     (y_s[0]),
    .zc_r    (z_s[0]),
    .n_r     (n_s[0])
  );
  assign res_s[0] = '0;

  // Square root of one minus z squared, one result bit per stage.
  for (genvar j = 0; j < NS; j++) begin : g_sqrt
    nll_sqrt_step #(.FRAC(FRAC), .K(FRAC - j)) u_step (
      .clk   (clk),
      .en    (en),
      .n_in  (n_s[j]),
      .res_in(res_s[j]),
      .n_r   (n_s[j+1]),
      .res_r (res_s[j+1])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_s[j+1].valid <= 1'b0;
      end else if (en) begin
        ctl_s[j+1].valid <= ctl_s[j].valid;
      end
      if (en) begin
        ctl_s[j+1].pole <= ctl_s[j].pole;
        ctl_s[j+1].zpos <= ctl_s[j].zpos;
        x_s[j+1]        <= x_s[j];
        y_s[j+1]        <= y_s[j];
        z_s[j+1]        <= z_s[j];
      end
    end
  end

  // Load both rotators: azimuth from (x, y), polar angle from (z, sqrt).
  nll_cordic_prep u_prep_lat (
    .clk (clk),
    .en  (en),
    .x_in(CW'(x_s[NS])),
    .y_in(CW'(y_s[NS])),
    .d_r (lat_c[0])
  );

  nll_cordic_prep u_prep_lon (
    .clk (clk),
    .en  (en),
    .x_in(CW'($signed(z_s[NS]))),
    .y_in($signed(CW'(res_s[NS]))),
    .d_r (lon_c[0])
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_c[0].valid <= 1'b0;
    end else if (en) begin
      ctl_c[0].valid <= ctl_s[NS].valid;
    end
    if (en) begin
      ctl_c[0].pole <= ctl_s[NS].pole;
      ctl_c[0].zpos <= ctl_s[NS].zpos;
    end
  end

  // Rotator iterations, one stage each, both lanes side by side.
  for (genvar i = 0; i < ITER; i++) begin : g_cordic
    nll_cordic_step #(.I(i)) u_lat (
      .clk (clk),
      .en  (en),
      .d_in(lat_c[i]),
      .d_r (lat_c[i+1])
    );

    nll_cordic_step #(.I(i)) u_lon (
      .clk (clk),
      .en  (en),
      .d_in(lon_c[i]),
      .d_r (lon_c[i+1])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_c[i+1].valid <= 1'b0;
      end else if (en) begin
        ctl_c[i+1].valid <= ctl_c[i].valid;
      end
      if (en) begin
        ctl_c[i+1].pole <= ctl_c[i].pole;
        ctl_c[i+1].zpos <= ctl_c[i].zpos;
      end
    end
  end

  // Byte codes into the output register.
  nll_code u_code (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .ctl_in (ctl_c[ITER]),
    .lon_in (lon_c[ITER]),
    .lat_in (lat_c[ITER]),
    .valid_r(out_ch.valid),
    .lon_r  (out_ch.longitude_code),
    .lat_r  (out_ch.latitude_code)
  );

`ifndef SYNTHESIS
  // The polar code never goes beyond half a turn.
  a_lon_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.longitude_code <= 8'd128))
    else $error("longitude code above half a turn");

  // A pole word leaves with a zero azimuth.
  a_pole_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (en && ctl_c[ITER].valid && ctl_c[ITER].pole) |=>
      (out_ch.valid && (out_ch.latitude_code == 8'd0)))
    else $error("pole word has a nonzero azimuth");

  // A bubble in the last stage empties the output register.
  a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    (en && !ctl_c[ITER].valid) |=> !out_ch.valid)
    else $error("output word appeared from a bubble");
`endif

endmodule

@@ sv/nll_front.sv @@
module nll_front
  import nll_pkg::*;
#(
  parameter int FRAC = FRAC_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic signed [COMP_W-1:0] in_x,
  input  logic signed [COMP_W-1:0] in_y,
  input  logic signed [COMP_W-1:0] in_z,
  output ctl_t                     ctl_r,
  output logic signed [COMP_W-1:0] x_r,
  output logic signed [COMP_W-1:0] y_r,
  output logic [((FRAC+2 > COMP_W+1) ? FRAC+2 : COMP_W+1)-1:0] zc_r,
  output logic [2*FRAC+1:0]        n_r
);

  localparam int ZW = (FRAC+2 > COMP_W+1) ? FRAC+2 : COMP_W+1;
  localparam int NW = 2*FRAC+2;

  logic signed [ZW-1:0] one;
  logic signed [ZW-1:0] zs;
  logic signed [ZW-1:0] zc;
  logic [FRAC:0]        zz;
  logic [NW-1:0]        sq;
  ctl_t                 ctl_nxt;

  // Clamp z to plus or minus one and form one minus z squared.
  always_comb begin
    one = ZW'(1) <<< FRAC;
    zs  = ZW'(in_z);
    zc  = zs;
    if (zs > one) begin
      zc = one;
    end else if (zs < -one) begin
      zc = -one;
    end
    zz = (zc < 0) ? (FRAC+1)'(-zc) : (FRAC+1)'(zc);
    sq = NW'(zz) * NW'(zz);
    ctl_nxt.valid = in_valid;
    ctl_nxt.pole  = (in_x == '0) && (in_y == '0);
    ctl_nxt.zpos  = (in_z > 0);
  end

  // Valid has a reset; payload does not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r.valid <= ctl_nxt.valid;
    end
    if (en) begin
      ctl_r.pole <= ctl_nxt.pole;
      ctl_r.zpos <= ctl_nxt.zpos;
      x_r        <= in_x;
      y_r        <= in_y;
      zc_r       <= zc;
      n_r        <= (NW'(1) << (2*FRAC)) - sq;
    end
  end

endmodule

@@ sv/nll_sqrt_step.sv @@
module nll_sqrt_step
  import nll_pkg::*;
#(
  parameter int FRAC = FRAC_DEF,
  parameter int K    = 0
) (
  input  logic              clk,
  input  logic              en,
  input  logic [2*FRAC+1:0] n_in,
  input  logic [2*FRAC+1:0] res_in,
  output logic [2*FRAC+1:0] n_r,
  output logic [2*FRAC+1:0] res_r
);

  localparam int NW = 2*FRAC+2;

  logic [NW-1:0] bit_w;
  logic [NW-1:0] trial;
  logic [NW-1:0] n_nxt;
  logic [NW-1:0] res_nxt;

  // One result bit: try res + 4^K against the remainder.
  always_comb begin
    bit_w = NW'(1) << (2*K);
    trial = res_in + bit_w;
    if (n_in >= trial) begin
      n_nxt   = n_in - trial;
      res_nxt = (res_in >> 1) + bit_w;
    end else begin
      n_nxt   = n_in;
      res_nxt = res_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r   <= n_nxt;
      res_r <= res_nxt;
    end
  end

endmodule

@@ sv/nll_cordic_prep.sv @@
module nll_cordic_prep
  import nll_pkg::*;
(
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  output cord_t                d_r
);

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  cord_t                d_nxt;

  // Points on the x axis are settled here; others are scaled and folded into the right half.
  always_comb begin
    xs          = x_in <<< PRESCALE_SH;
    ys          = y_in <<< PRESCALE_SH;
    d_nxt.fixed = (y_in == '0);
    d_nxt.acc   = '0;
    d_nxt.x     = xs;
    d_nxt.y     = ys;
    if (y_in == '0) begin
      d_nxt.acc = (x_in >= 0) ? '0 : HALF_TURN;
    end else if (x_in < 0) begin
      d_nxt.x   = -xs;
      d_nxt.y   = -ys;
      d_nxt.acc = HALF_TURN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

endmodule

@@ sv/nll_cordic_step.sv @@
module nll_cordic_step
  import nll_pkg::*;
#(
  parameter int I = 0
) (
  input  logic  clk,
  input  logic  en,
  input  cord_t d_in,
  output cord_t d_r
);

  logic signed [CW-1:0] xi;
  logic signed [CW-1:0] yi;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [AW-1:0] acci;
  logic signed [AW-1:0] a;
  cord_t                d_nxt;

  // One vectoring rotation toward the x axis.
  always_comb begin
    xi    = $signed(d_in.x);
    yi    = $signed(d_in.y);
    acci  = $signed(d_in.acc);
    dx    = yi >>> I;
    dy    = xi >>> I;
    a     = $signed(AW'(atan_turn(5'(I))));
    d_nxt = d_in;
    if (!d_in.fixed) begin
      if (yi >= 0) begin
        d_nxt.x   = xi + dx;
        d_nxt.y   = yi - dy;
        d_nxt.acc = acci + a;
      end else begin
        d_nxt.x   = xi - dx;
        d_nxt.y   = yi + dy;
        d_nxt.acc = acci - a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

endmodule

@@ sv/nll_code.sv @@
module nll_code
  import nll_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  ctl_t       ctl_in,
  input  cord_t      lon_in,
  input  cord_t      lat_in,
  output logic       valid_r,
  output logic [7:0] lon_r,
  output logic [7:0] lat_r
);

  // Wrap an angle into one turn, scale by 255 and keep the low byte, truncating toward zero.
  function automatic logic [7:0] to_code(input logic signed [AW-1:0] a_in);
    logic signed [AW-1:0] a;
    logic [AW-1:0]        mag;
    logic [AW+7:0]        prod;
    logic [7:0]           c;
    a = a_in;
    if (a > HALF_TURN) begin
      a = a - FULL_TURN;
    end else if (a <= -HALF_TURN) begin
      a = a + FULL_TURN;
    end
    mag  = (a < 0) ? AW'(-a) : AW'(a);
    prod = {mag, 8'b0} - (AW+8)'(mag);
    c    = prod[39:32];
    if (a < 0) begin
      c = -c;
    end
    return c;
  endfunction

  logic [7:0] lon_nxt;
  logic [7:0] lat_nxt;

  // A vector along z gives a fixed code.
  always_comb begin
    if (ctl_in.pole) begin
      lon_nxt = ctl_in.zpos ? 8'd0 : 8'd128;
      lat_nxt = 8'd0;
    end else begin
      lon_nxt = to_code($signed(lon_in.acc));
      lat_nxt = to_code($signed(lat_in.acc));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lon_r <= lon_nxt;
      lat_r <= lat_nxt;
    end
  end

endmodule
